// File: rtl/sitda_pkg.sv
package sitda_pkg;

    localparam int VALUE_BITS = 32;
    localparam int DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_BITS   = 4 * DIGITS;
    localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
    localparam int DCNT_BITS  = $clog2(DIGITS + 1);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [3:0] DAB_LIMIT = 4'd5;
    localparam logic [3:0] DAB_ADD   = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_STRIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic dabble;
        logic strip;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic one_left;
        logic neg;
        logic out_free;
    } t_status;

endpackage

// File: rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text.
// Input channel: i_value with i_valid / o_stall. A transfer happens on a rising
// edge with i_valid high and o_stall low. o_stall is low only while the block
// is idle, so one number is converted at a time.
// Output channel: o_ch, o_last with o_valid / i_stall. One character per
// transfer, most significant first, a leading '-' for negative numbers,
// o_last high on the final digit. Zero prints as "0".
// Sequence: after the input transfer, double dabble with one step per input
// bit, then one strip step per suppressed leading zero (up to 9), one
// decision step, then one step per character (up to 11) while the receiver
// keeps i_stall low. Stripped zeros plus digits always come to 10.
// The next number is taken once the last character sits in the output
// register, even if that character has not transferred yet.
// Receiver stall: the output register holds its character and the sequencer
// waits before emitting the next character.
// Reset (synchronous, active low): returns to idle and empties the output
// register. No state is kept between numbers.
module signed_int_to_decimal_ascii (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [sitda_pkg::VALUE_BITS-1:0] i_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [7:0]                       o_ch,
    output logic                             o_last
);
    import sitda_pkg::*;

    t_cmd    cmd;
    t_status status;

    sitda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    sitda_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_value),
        .i_stall  (i_stall),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_valid),
        .o_ch     (o_ch),
        .o_last   (o_last)
    );

endmodule

// File: rtl/sitda_datapath.sv
module sitda_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [sitda_pkg::VALUE_BITS-1:0] i_value,
    input  logic                             i_stall,
    input  sitda_pkg::t_cmd                  i_cmd,
    output sitda_pkg::t_status               o_status,
    output logic                             o_valid,
    output logic [7:0]                       o_ch,
    output logic                             o_last
);
    import sitda_pkg::*;

    logic [VALUE_BITS-1:0] r_mag;
    logic                  r_neg;
    logic [BCD_BITS-1:0]   r_bcd;
    logic [CNT_BITS-1:0]   r_bits;
    logic [DCNT_BITS-1:0]  r_ndig;
    logic                  r_valid;
    logic [7:0]            r_ch;
    logic                  r_last;

    logic [BCD_BITS-1:0]   adj;
    logic [3:0]            top;

    assign top = r_bcd[BCD_BITS-1 -: 4];

    // add-3 correction per BCD digit
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= DAB_LIMIT) begin
                adj[4*d +: 4] = r_bcd[4*d +: 4] + DAB_ADD;
            end else begin
                adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag  <= i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
            r_neg  <= i_value[VALUE_BITS-1];
            r_bcd  <= '0;
            r_bits <= CNT_BITS'(VALUE_BITS);
            r_ndig <= DCNT_BITS'(DIGITS);
        end else if (i_cmd.dabble) begin
            r_bcd  <= {adj[BCD_BITS-2:0], r_mag[VALUE_BITS-1]};
            r_mag  <= {r_mag[VALUE_BITS-2:0], 1'b0};
            r_bits <= r_bits - 1'b1;
        end else if (i_cmd.strip || i_cmd.emit_digit) begin
            r_bcd  <= {r_bcd[BCD_BITS-5:0], 4'b0000};
            r_ndig <= r_ndig - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_ch   <= CH_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_ch   <= CH_ZERO + 8'(top);
            r_last <= (r_ndig == DCNT_BITS'(1));
        end
    end

    assign o_status.conv_done = (r_bits == CNT_BITS'(1));
    assign o_status.top_zero  = (top == 4'd0);
    assign o_status.one_left  = (r_ndig == DCNT_BITS'(1));
    assign o_status.neg       = r_neg;
    assign o_status.out_free  = !r_valid || !i_stall;

    assign o_valid = r_valid;
    assign o_ch    = r_ch;
    assign o_last  = r_last;

endmodule

// File: rtl/sitda_ctrl.sv
module sitda_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sitda_pkg::t_status i_status,
    output sitda_pkg::t_cmd    o_cmd,
    output logic               o_stall
);
    import sitda_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.dabble = 1'b1;
                if (i_status.conv_done) begin
                    n_state = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (i_status.top_zero && !i_status.one_left) begin
                    o_cmd.strip = 1'b1;
                end else if (i_status.neg) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_status.one_left) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/sitda_checker.sv
module sitda_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_ch,
    input logic       o_last
);
    import sitda_pkg::*;

    a_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ch) && $stable(o_last))
        else $error("output changed while stalled");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ch == CH_MINUS) || ((o_ch >= CH_ZERO) && (o_ch <= CH_NINE)))
        else $error("character outside minus and digits");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_ch == CH_MINUS) |-> !o_last)
        else $error("minus sign flagged as last");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while converting");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (.*);

// File: tb/tb_signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;
    import sitda_pkg::*;

    localparam int          CLK_PERIOD   = 12;
    localparam int          RESET_CYCLES = 11;
    localparam int          N_RANDOM     = 350;
    localparam int          N_DIRECTED   = 19;
    localparam int          HOLD_START   = 2500;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_LIMIT  = 20000;
    localparam int          TAIL_CYCLES  = 80;
    localparam logic [31:0] RADIX        = 32'd10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_TOGGLE
    } t_rx_mode;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic [VALUE_BITS-1:0] i_value = '0;
    logic                  i_stall = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [7:0]            o_ch;
    logic                  o_last;

    t_text_char expected_chars[$];
    t_text_char next_char;
    int         n_errors    = 0;
    int         n_numbers   = 0;
    int         n_negative  = 0;
    int         n_chars     = 0;
    int         burst_left  = 0;
    bit         steady      = 1'b0;

    t_rx_mode   rx_mode     = RX_FREE;
    int         rx_mode_left = 0;
    int         rx_cycles   = 0;
    int         hold_left   = 0;
    bit         hold_done   = 1'b0;

    int    dir_value [N_DIRECTED];
    string dir_text  [N_DIRECTED];

    signed_int_to_decimal_ascii dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ch    (o_ch),
        .o_last  (o_last)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("timeout at %0t", $time);
        $display("tb_signed_int_to_decimal_ascii: errors");
        $finish;
    end

    function automatic void predict_decimal_text(input logic [31:0] v);
        logic [31:0] mag;
        logic [7:0]  digits[$];
        mag = v[31] ? (32'd0 - v) : v;
        do begin
            digits.push_front(CH_ZERO + 8'(mag % RADIX));
            mag = mag / RADIX;
        end while (mag != 0);
        if (v[31]) begin
            expected_chars.push_back('{ch: CH_MINUS, last: 1'b0});
        end
        foreach (digits[i]) begin
            expected_chars.push_back('{ch: digits[i], last: (i == digits.size() - 1)});
        end
    endfunction

    function automatic void push_typed_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            expected_chars.push_back('{ch: txt[i], last: (i == txt.len() - 1)});
        end
    endfunction

    function automatic logic [31:0] random_value();
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned m;
        int              k;
        logic [31:0]     v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6, 7: begin
                k  = $urandom_range(1, 10);
                lo = 1;
                for (int i = 1; i < k; i++) lo = lo * 10;
                hi = lo * 10 - 1;
                if (hi > 64'd2147483647) hi = 64'd2147483647;
                m  = lo + ({$urandom, $urandom} % (hi - lo + 1));
                v  = m[31:0];
                if ($urandom_range(0, 1)) v = 32'd0 - v;
            end
            8: v = 32'($signed($urandom_range(0, 40)) - 20);
            default: begin
                if ($urandom_range(0, 1)) v = 32'h8000_0000 + $urandom_range(0, 3);
                else                      v = 32'h7FFF_FFFF - $urandom_range(0, 3);
            end
        endcase
        return v;
    endfunction

    // sender: bursts with gaps; nothing lowered in the step where it is raised again
    task automatic pace();
        int gap;
        if (steady || burst_left > 0) begin
            if (burst_left > 0) burst_left--;
        end else begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic send_value(input logic [31:0] v, input string txt);
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        if (txt.len() != 0) push_typed_text(txt);
        else                predict_decimal_text(v);
        n_numbers++;
        if (v[31]) n_negative++;
    endtask

    // receiver stall pattern, with one long hold-off to back the block up
    always @(posedge i_clk) begin
        rx_cycles++;
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (!hold_done && rx_cycles >= HOLD_START) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(40, 200);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_FREE:   i_stall <= 1'b0;
                RX_LIGHT:  i_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:  i_stall <= ($urandom_range(0, 3) != 0);
                RX_TOGGLE: i_stall <= ~i_stall;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected transfer: expected none, actual ch=%h last=%b",
                         $time, o_ch, o_last);
                n_errors++;
            end else begin
                next_char = expected_chars.pop_front();
                if (o_ch !== next_char.ch) begin
                    $display("%0t: ch mismatch: expected %h, actual %h",
                             $time, next_char.ch, o_ch);
                    n_errors++;
                end
                if (o_last !== next_char.last) begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, next_char.last, o_last);
                    n_errors++;
                end
                n_chars++;
            end
        end
    end

    initial begin
        int drain;
        dir_value = '{0, 1, -1, 9, 10, -10, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                      1000000000, -999999999, 100, 12345, -98765, 32'hAAAA_AAAA,
                      32'h5555_5555, -100000, 999999999, 32'h0000_FFFF};
        dir_text  = '{"0", "1", "-1", "9", "10", "-10", "2147483647", "-2147483648",
                      "-2147483647", "1000000000", "-999999999", "", "", "", "", "",
                      "", "", ""};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            pace();
            send_value(dir_value[i], dir_text[i]);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            steady = (i >= 150 && i < 190);
            pace();
            send_value(random_value(), "");
        end
        i_valid <= 1'b0;

        drain = 0;
        while (expected_chars.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        if (expected_chars.size() != 0) begin
            $display("%0t: %0d characters never arrived", $time, expected_chars.size());
            $display("tb_signed_int_to_decimal_ascii: errors");
            $finish;
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            $display("%0d numbers converted (%0d negative), %0d characters checked",
                     n_numbers, n_negative, n_chars);
            $display("extremes, all digit counts, receiver hold-off of %0d cycles",
                     HOLD_CYCLES);
            if (n_errors == 0) begin
                $display("tb_signed_int_to_decimal_ascii: clean");
            end else begin
                $display("tb_signed_int_to_decimal_ascii: errors");
            end
            $finish;
        end
    end

endmodule
